// File: design/inverted_frame_receiver_macros.svh
// Assertion helpers used by the checker file.
`ifndef INVERTED_FRAME_RECEIVER_MACROS_SVH
`define INVERTED_FRAME_RECEIVER_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define IFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define IFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ifr_pkg.sv
`timescale 1ns / 1ps

package ifr_pkg;

  // Frame layout
  localparam int unsigned MIN_FRAME       = 11;
  localparam int unsigned MAX_PAYLOAD_DEF = 5;
  localparam int unsigned HEADER_BYTES    = 9;
  localparam int unsigned SRC_FIRST       = 3;
  localparam int unsigned SRC_LAST        = 5;
  localparam int unsigned DST_LAST        = 8;

  // Configuration port
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_LSB = 2;
  localparam logic        REG_EXPECTED_DIRECTION = 1'b0;

  typedef enum logic [6:0] {
    ST_TYPE = 7'b0000001,
    ST_LEN  = 7'b0000010,
    ST_DIR  = 7'b0000100,
    ST_SRC  = 7'b0001000,
    ST_DST  = 7'b0010000,
    ST_DATA = 7'b0100000,
    ST_CHK  = 7'b1000000
  } ifr_stage_e;

  typedef struct packed {
    logic length_ok;
    logic direction_ok;
    logic checksum_ok;
  } ifr_flags_t;

endpackage

// File: design/inverted_frame_receiver.sv
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register and is decoded when it steps; the
//   closing checksum byte's result goes into the output register and drives m_axis_tvalid.
// Throughput: one byte per cycle; the only stall is a closing byte meeting a full,
//   untaken output register, and a frame of 11 to 16 bytes yields one result item.
// Reset (rst_ni low, asynchronous): waits for a type byte, sums and holds cleared,
//   both registers empty, expected_direction zero.
module inverted_frame_receiver import ifr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int unsigned LEN_W    = $clog2(MIN_FRAME + MAX_PAYLOAD + 1),
  localparam int unsigned CNT_W    = $clog2(MAX_PAYLOAD + 1),
  localparam int unsigned PL_W     = 8 * MAX_PAYLOAD,
  localparam int unsigned OUT_BITS = 8 + LEN_W + 1 + 1 + 24 + 24 + CNT_W + PL_W + 1,
  localparam int unsigned TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // rx_byte
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // from bit 0 up: msg_type, frame_length, length_ok, direction_ok, source_address,
  // dest_address, payload_count, payload, checksum_ok, zero fill
  output logic [TDATA_W-1:0]    m_axis_tdata,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [7:0]       expected_direction;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q, in_byte_d;

  // deframer outputs
  logic             emit;
  logic [7:0]       msg_type;
  logic [LEN_W-1:0] frame_length;
  logic [23:0]      source_address;
  logic [23:0]      dest_address;
  logic [CNT_W-1:0] payload_count;
  logic [PL_W-1:0]  payload;
  ifr_flags_t       flags;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [TDATA_W-1:0] out_data_q, out_data_d;

  logic             out_free;
  logic             step;
  logic             in_accept;

  ifr_cfg_regs u_cfg (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .expected_direction_o (expected_direction)
  );

  // A byte leaves the input register unless it closes a frame and the output
  // register still holds a result nobody has taken.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || step;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
      in_byte_d  = s_axis_tdata;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  ifr_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_deframer (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (step),
    .byte_i               (in_byte_q),
    .expected_direction_i (expected_direction),
    .emit_o               (emit),
    .msg_type_o           (msg_type),
    .frame_length_o       (frame_length),
    .source_address_o     (source_address),
    .dest_address_o       (dest_address),
    .payload_count_o      (payload_count),
    .payload_o            (payload),
    .flags_o              (flags)
  );

  // Load the result when the closing byte steps; drop it once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (step && emit) begin
      out_valid_d = 1'b1;
      out_data_d  = TDATA_W'({flags.checksum_ok, payload, payload_count, dest_address,
                              source_address, flags.direction_ok, flags.length_ok,
                              frame_length, msg_type});
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_byte_q  <= in_byte_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: design/ifr_cfg_regs.sv
`timescale 1ns / 1ps

module ifr_cfg_regs import ifr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [7:0]            expected_direction_o
);

  logic [7:0] exp_dir_q, exp_dir_d;
  logic       hit;

  assign pready = 1'b1;
  assign hit    = (paddr[ADDR_W-1:CFG_IDX_LSB] == REG_EXPECTED_DIRECTION);

  always_comb begin
    exp_dir_d = exp_dir_q;
    if (psel && penable && pwrite && pready && hit) begin
      exp_dir_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_dir_q <= '0;
    end else begin
      exp_dir_q <= exp_dir_d;
    end
  end

  assign prdata               = hit ? CFG_DATA_W'(exp_dir_q) : '0;
  assign expected_direction_o = exp_dir_q;

endmodule

// File: design/ifr_deframer.sv
`timescale 1ns / 1ps

module ifr_deframer import ifr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int unsigned LEN_W = $clog2(MIN_FRAME + MAX_PAYLOAD + 1),
  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1),
  localparam int unsigned PL_W  = 8 * MAX_PAYLOAD
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       expected_direction_i,
  output logic             emit_o,
  output logic [7:0]       msg_type_o,
  output logic [LEN_W-1:0] frame_length_o,
  output logic [23:0]      source_address_o,
  output logic [23:0]      dest_address_o,
  output logic [CNT_W-1:0] payload_count_o,
  output logic [PL_W-1:0]  payload_o,
  output ifr_flags_t       flags_o
);

  localparam int unsigned IDX_W     = $clog2(MIN_FRAME + MAX_PAYLOAD);
  localparam int unsigned MAX_FRAME = MIN_FRAME + MAX_PAYLOAD;

  ifr_stage_e       stage_q, stage_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       length_q, length_d;
  logic [7:0]       dir_q, dir_d;
  logic [23:0]      src_q, src_d;
  logic [23:0]      dst_q, dst_d;
  logic [PL_W-1:0]  pl_q, pl_d;
  logic [7:0]       chk_hi_q, chk_hi_d;

  logic [7:0]       inv;
  logic             len_lo, len_hi;
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] count;
  logic [LEN_W:0]   idx_p1;
  logic             chk_last;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] pos;
  logic [1:0]       src_lane;

  assign inv     = ~byte_i;
  assign len_lo  = (length_q < 8'(MIN_FRAME));
  assign len_hi  = (length_q > 8'(MAX_FRAME));
  assign len     = len_lo ? LEN_W'(MIN_FRAME) :
                   len_hi ? LEN_W'(MAX_FRAME) : length_q[LEN_W-1:0];
  assign count   = CNT_W'(len - LEN_W'(MIN_FRAME));
  assign idx_p1  = (LEN_W+1)'(idx_q) + (LEN_W+1)'(1);
  assign chk_last = !(idx_p1 < {1'b0, len});
  assign idx_inc = idx_q + IDX_W'(1);
  assign pos     = idx_q - IDX_W'(HEADER_BYTES);
  assign src_lane = 2'(idx_q - IDX_W'(SRC_FIRST));

  assign emit_o = (stage_q == ST_CHK) && chk_last;

  always_comb begin
    stage_d  = stage_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    type_d   = type_q;
    length_d = length_q;
    dir_d    = dir_q;
    src_d    = src_q;
    dst_d    = dst_q;
    pl_d     = pl_q;
    chk_hi_d = chk_hi_q;
    if (step_i) begin
      case (stage_q)
        ST_LEN: begin
          sum_d    = sum_q + 16'(byte_i);
          length_d = inv;
          idx_d    = IDX_W'(2);
          stage_d  = ST_DIR;
        end
        ST_DIR: begin
          sum_d   = sum_q + 16'(byte_i);
          dir_d   = inv;
          idx_d   = IDX_W'(SRC_FIRST);
          stage_d = ST_SRC;
        end
        ST_SRC: begin
          sum_d = sum_q + 16'(byte_i);
          case (src_lane)
            2'd0:    src_d[7:0]   = src_q[7:0]   | inv;
            2'd1:    src_d[15:8]  = src_q[15:8]  | inv;
            2'd2:    src_d[23:16] = src_q[23:16] | inv;
            default: src_d        = src_q;
          endcase
          if (idx_q >= IDX_W'(SRC_LAST)) begin
            stage_d = ST_DST;
          end
          idx_d = idx_inc;
        end
        ST_DST: begin
          sum_d = sum_q + 16'(byte_i);
          dst_d = {dst_q[15:0], inv};
          if (idx_q >= IDX_W'(DST_LAST)) begin
            stage_d = (count != '0) ? ST_DATA : ST_CHK;
          end
          idx_d = idx_inc;
        end
        ST_DATA: begin
          sum_d = sum_q + 16'(byte_i);
          for (int unsigned l = 0; l < MAX_PAYLOAD; l++) begin
            if (pos == IDX_W'(l)) begin
              pl_d[8*l +: 8] = pl_q[8*l +: 8] | inv;
            end
          end
          if ((IDX_W+1)'(pos) + (IDX_W+1)'(1) >= (IDX_W+1)'(count)) begin
            stage_d = ST_CHK;
          end
          idx_d = idx_inc;
        end
        ST_CHK: begin
          if (!chk_last) begin
            chk_hi_d = byte_i;
            idx_d    = idx_inc;
          end else begin
            stage_d = ST_TYPE;
            idx_d   = '0;
            sum_d   = '0;
          end
        end
        default: begin
          // type byte opens a frame; clear what the last frame left
          sum_d    = 16'(byte_i);
          type_d   = inv;
          length_d = '0;
          dir_d    = '0;
          src_d    = '0;
          dst_d    = '0;
          pl_d     = '0;
          chk_hi_d = '0;
          idx_d    = IDX_W'(1);
          stage_d  = ST_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= ST_TYPE;
      idx_q    <= '0;
      sum_q    <= '0;
      type_q   <= '0;
      length_q <= '0;
      dir_q    <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      pl_q     <= '0;
      chk_hi_q <= '0;
    end else begin
      stage_q  <= stage_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      type_q   <= type_d;
      length_q <= length_d;
      dir_q    <= dir_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      pl_q     <= pl_d;
      chk_hi_q <= chk_hi_d;
    end
  end

  assign msg_type_o             = type_q;
  assign frame_length_o         = len;
  assign source_address_o       = src_q;
  assign dest_address_o         = dst_q;
  assign payload_count_o        = count;
  assign payload_o              = pl_q;
  assign flags_o.length_ok      = !(len_lo || len_hi);
  assign flags_o.direction_ok   = (dir_q == expected_direction_i);
  assign flags_o.checksum_ok    = ({chk_hi_q, byte_i} == sum_q);

endmodule

// File: design/ifr_checker.sv
`timescale 1ns / 1ps
`include "inverted_frame_receiver_macros.svh"

module ifr_checker import ifr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int unsigned LEN_W    = $clog2(MIN_FRAME + MAX_PAYLOAD + 1),
  localparam int unsigned CNT_W    = $clog2(MAX_PAYLOAD + 1),
  localparam int unsigned PL_W     = 8 * MAX_PAYLOAD,
  localparam int unsigned OUT_BITS = 8 + LEN_W + 1 + 1 + 24 + 24 + CNT_W + PL_W + 1,
  localparam int unsigned TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned FL_LO  = 8;
  localparam int unsigned CNT_LO = FL_LO + LEN_W + 2 + 48;

  logic [LEN_W-1:0] fl;
  logic [CNT_W-1:0] cnt;

  assign fl  = m_axis_tdata[FL_LO +: LEN_W];
  assign cnt = m_axis_tdata[CNT_LO +: CNT_W];

  `IFR_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `IFR_ASSERT_SAME(a_len_range, m_axis_tvalid, fl >= LEN_W'(MIN_FRAME) && fl <= LEN_W'(MIN_FRAME + MAX_PAYLOAD), "frame_length outside clamp range")
  `IFR_ASSERT_SAME(a_count_match, m_axis_tvalid, cnt == CNT_W'(fl - LEN_W'(MIN_FRAME)), "payload_count disagrees with frame_length")

endmodule

bind inverted_frame_receiver ifr_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_ifr_checker (.*);
